// File: hw/rtl/tcba_pkg.sv
// ----------------------------------------------------------------------------
// tcba_pkg
// shared widths for the three channel block averager and its divider
// ----------------------------------------------------------------------------
package tcba_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int LIMIT_BITS  = 12;
    localparam int COUNT_BITS  = LIMIT_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + LIMIT_BITS;
    localparam int NUM_CH      = 3;
    localparam int CH_BITS     = 2;
    localparam int STEP_BITS   = $clog2(SAMPLE_BITS);
    localparam int DATA_BITS   = ((NUM_CH * SAMPLE_BITS + 7) / 8) * 8;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(4000);

endpackage

// File: hw/rtl/tcba_div.sv
// ----------------------------------------------------------------------------
// tcba_div
// restoring divider, one quotient bit per cycle, quotient known to fit
// ----------------------------------------------------------------------------
module tcba_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [tcba_pkg::SUM_BITS-1:0]    i_dividend,
    input  logic [tcba_pkg::COUNT_BITS-1:0]  i_divisor,
    output logic                             o_done,
    output logic [tcba_pkg::SAMPLE_BITS-1:0] o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [tcba_pkg::STEP_BITS-1:0]   r_step;
    logic [tcba_pkg::COUNT_BITS-1:0]  r_rem;
    logic [tcba_pkg::SAMPLE_BITS-1:0] r_shift;

    logic [tcba_pkg::COUNT_BITS:0]    w_trial;
    logic [tcba_pkg::COUNT_BITS:0]    w_diff;
    logic                             w_fit;
    logic                             w_last;

    assign w_trial = {r_rem, r_shift[tcba_pkg::SAMPLE_BITS-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_fit   = (w_trial >= {1'b0, i_divisor});
    assign w_last  = (r_step == tcba_pkg::STEP_BITS'(tcba_pkg::SAMPLE_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && w_last;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_step  <= '0;
                r_rem   <= tcba_pkg::COUNT_BITS'(
                               i_dividend[tcba_pkg::SUM_BITS-1:tcba_pkg::SAMPLE_BITS]);
                r_shift <= i_dividend[tcba_pkg::SAMPLE_BITS-1:0];
            end else if (r_busy) begin
                r_rem   <= w_fit ? w_diff[tcba_pkg::COUNT_BITS-1:0]
                                 : w_trial[tcba_pkg::COUNT_BITS-1:0];
                r_shift <= {r_shift[tcba_pkg::SAMPLE_BITS-2:0], w_fit};
                r_step  <= r_step + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_shift;

endmodule

// File: hw/rtl/three_channel_block_averager.sv
// ----------------------------------------------------------------------------
// three_channel_block_averager
// block averaging of three converter channels with a shared divider
// ----------------------------------------------------------------------------
// usage:
//   slave stream takes one converter frame per transfer (three samples in
//   tdata). every frame gives exactly one master stream transfer with the
//   three held window averages in tdata and a window end flag in tuser.
//   a window closes when the frame count exceeds the limit written through
//   i_cfg_wr_en / i_cfg_wr_data (4000 after reset); the averages become
//   floor(sum / count) and the sums and count clear.
// processing:
//   a frame that does not close a window goes from S_IDLE through S_OUT
//   into the output register. a closing frame passes S_DIV first: the
//   single restoring divider runs 12 bit steps per channel, for three
//   channels in turn. tready is low while a frame is processed, so the
//   next frame is taken only once this one is loaded for output.
// reset:
//   synchronous, active low; sums, count and averages clear, limit is 4000.
// stall:
//   one result waits in the output register while the next frame is taken;
//   processing of that frame holds before the output load until it drains.
// ----------------------------------------------------------------------------
module three_channel_block_averager (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tcba_pkg::LIMIT_BITS-1:0]  i_cfg_wr_data,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // current_sample, force_one_sample, force_two_sample, zero pad
    input  logic [tcba_pkg::DATA_BITS-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // current_average, force_one_average, force_two_average, zero pad
    output logic [tcba_pkg::DATA_BITS-1:0]   o_m_tdata,
    // window_done
    output logic                             o_m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state                           r_state;
    logic [tcba_pkg::LIMIT_BITS-1:0]  r_limit;
    logic [tcba_pkg::COUNT_BITS-1:0]  r_count;
    logic [tcba_pkg::SUM_BITS-1:0]    r_sum [tcba_pkg::NUM_CH];
    logic [tcba_pkg::SAMPLE_BITS-1:0] r_avg [tcba_pkg::NUM_CH];
    logic [tcba_pkg::CH_BITS-1:0]     r_ch;
    logic                             r_div_start;
    logic                             r_win;
    logic                             r_out_valid;
    logic [tcba_pkg::DATA_BITS-1:0]   r_out_data;
    logic                             r_out_user;

    logic                             w_accept;
    logic [tcba_pkg::COUNT_BITS-1:0]  w_count_inc;
    logic                             w_close;
    logic                             w_div_done;
    logic [tcba_pkg::SAMPLE_BITS-1:0] w_quotient;
    logic [tcba_pkg::DATA_BITS-1:0]   w_pack;
    logic                             w_last_ch;
    logic                             w_out_load;

    assign o_s_tready  = (r_state == S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_count_inc = r_count + 1'b1;
    assign w_close     = (w_count_inc > {1'b0, r_limit});
    assign w_last_ch   = (r_ch == tcba_pkg::CH_BITS'(tcba_pkg::NUM_CH - 1));
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    always_comb begin
        w_pack = '0;
        for (int c = 0; c < tcba_pkg::NUM_CH; c++) begin
            w_pack[c*tcba_pkg::SAMPLE_BITS +: tcba_pkg::SAMPLE_BITS] = r_avg[c];
        end
    end

    tcba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_sum[r_ch]),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= tcba_pkg::LIMIT_RESET;
            r_count     <= '0;
            r_ch        <= '0;
            r_div_start <= 1'b0;
            r_win       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < tcba_pkg::NUM_CH; c++) begin
                r_sum[c] <= '0;
                r_avg[c] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_div_start <= (w_accept && w_close)
                           || ((r_state == S_DIV) && w_div_done && !w_last_ch);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= w_count_inc;
                        for (int c = 0; c < tcba_pkg::NUM_CH; c++) begin
                            r_sum[c] <= r_sum[c] + tcba_pkg::SUM_BITS'(
                                i_s_tdata[c*tcba_pkg::SAMPLE_BITS +: tcba_pkg::SAMPLE_BITS]);
                        end
                        r_win <= w_close;
                        if (w_close) begin
                            r_ch    <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_avg[r_ch] <= w_quotient;
                        if (w_last_ch) begin
                            r_count <= '0;
                            for (int c = 0; c < tcba_pkg::NUM_CH; c++) begin
                                r_sum[c] <= '0;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_ch <= r_ch + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_data <= w_pack;
                        r_out_user <= r_win;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

`ifndef SYNTHESIS
    // divider finishes only while the sequencer waits on it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide phase");

    // frame count never exceeds one above the largest limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tcba_pkg::COUNT_BITS'(1 << tcba_pkg::LIMIT_BITS))
        else $error("frame count out of range");

    // last channel divide clears the window and moves to output load
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && w_div_done
            && (r_ch == tcba_pkg::CH_BITS'(tcba_pkg::NUM_CH - 1))
        |=> (r_count == '0) && (r_state == S_OUT))
        else $error("window not cleared after last divide");

    // an input transfer always leads to a divide or an output load
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DIV) || (r_state == S_OUT))
        else $error("input transfer not processed");

    // a divide phase is never entered without a window close
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_win)
        else $error("divide without window close");
`endif

endmodule

// File: verif/three_channel_block_averager_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_block_averager_checker
// watches the frame and result streams of the block averager, keeps its own
// running sums, frame count, held averages and window limit, and compares
// every result transfer field by field with the oldest predicted result
// ----------------------------------------------------------------------------
module three_channel_block_averager_checker
    import tcba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [LIMIT_BITS-1:0]  i_cfg_wr_data,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [DATA_BITS-1:0]   i_s_tdata,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [DATA_BITS-1:0]   i_m_tdata,
    input  logic                   i_m_tuser,
    output int                     o_mismatch_count,
    output int                     o_outstanding
);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] current_avg;
        logic [SAMPLE_BITS-1:0] force_one_avg;
        logic [SAMPLE_BITS-1:0] force_two_avg;
        logic                   window_done;
    } t_window_result;

    logic [LIMIT_BITS-1:0]  window_limit;
    logic [COUNT_BITS-1:0]  frame_count;
    logic [SUM_BITS:0]      channel_sum [NUM_CH];
    logic [SAMPLE_BITS-1:0] channel_avg [NUM_CH];
    t_window_result         expected_averages_q [$];
    int                     mismatch_count = 0;
    int                     outstanding = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_outstanding    = outstanding;

    function automatic t_window_result accumulate_frame(input logic [DATA_BITS-1:0] frame);
        t_window_result res;
        frame_count = frame_count + 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            channel_sum[c] = channel_sum[c] + frame[c*SAMPLE_BITS +: SAMPLE_BITS];
        end
        res.window_done = (frame_count > window_limit);
        if (res.window_done) begin
            for (int c = 0; c < NUM_CH; c++) begin
                channel_avg[c] = SAMPLE_BITS'(channel_sum[c] / frame_count);
                channel_sum[c] = '0;
            end
            frame_count = '0;
        end
        res.current_avg   = channel_avg[0];
        res.force_one_avg = channel_avg[1];
        res.force_two_avg = channel_avg[2];
        return res;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_window_result want;
        if (!i_rst_n) begin
            window_limit = LIMIT_RESET;
            frame_count  = '0;
            for (int c = 0; c < NUM_CH; c++) begin
                channel_sum[c] = '0;
                channel_avg[c] = '0;
            end
            expected_averages_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                expected_averages_q.push_back(accumulate_frame(i_s_tdata));
            end
            if (i_cfg_wr_en) begin
                window_limit = i_cfg_wr_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_averages_q.size() == 0) begin
                    $error("result transfer with no frame outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_averages_q.pop_front();
                    check_field("current_average", want.current_avg,
                                i_m_tdata[0 +: SAMPLE_BITS]);
                    check_field("force_one_average", want.force_one_avg,
                                i_m_tdata[SAMPLE_BITS +: SAMPLE_BITS]);
                    check_field("force_two_average", want.force_two_avg,
                                i_m_tdata[2*SAMPLE_BITS +: SAMPLE_BITS]);
                    check_field("window_done", want.window_done, i_m_tuser);
                end
            end
        end
        outstanding <= expected_averages_q.size();
    end

endmodule

// File: verif/tb_three_channel_block_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_channel_block_averager
// drives converter frames into the block averager under several window
// limits and idle patterns: a directed part on extremes and window edge
// cases, then random blocks of frames; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_three_channel_block_averager;
    import tcba_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 60;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [LIMIT_BITS-1:0] i_cfg_wr_data = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [DATA_BITS-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [DATA_BITS-1:0]  o_m_tdata;
    logic                  o_m_tuser;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    three_channel_block_averager uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    three_channel_block_averager_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_s_tvalid       (i_s_tvalid),
        .i_s_tready       (o_s_tready),
        .i_s_tdata        (i_s_tdata),
        .i_m_tvalid       (o_m_tvalid),
        .i_m_tready       (i_m_tready),
        .i_m_tdata        (o_m_tdata),
        .i_m_tuser        (o_m_tuser),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_BITS'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_frame(input logic [SAMPLE_BITS-1:0] cur,
                              input logic [SAMPLE_BITS-1:0] f1,
                              input logic [SAMPLE_BITS-1:0] f2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= DATA_BITS'({f2, f1, cur});
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_random_frame();
        send_frame(pick_sample(), pick_sample(), pick_sample());
    endtask

    // hold off the sender until every result has been taken
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_limit(input logic [LIMIT_BITS-1:0] limit);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= limit;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        int pick;
        logic [LIMIT_BITS-1:0] limit;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit: nothing closes yet, averages stay zero
        send_frame('0, '0, '0);
        send_frame('1, '1, '1);
        send_frame(12'h555, 12'hAAA, 12'h5A5);

        // zero limit: every frame closes its own window
        write_window_limit('0);
        send_frame('1, '0, 12'h800);
        send_frame('0, '1, 12'h001);
        send_frame(12'h7FF, 12'h800, 12'hFFE);

        write_window_limit(12'd1);
        send_frame('1, '1, '1);
        send_frame('1, '1, '1);
        send_frame('0, 12'h001, '1);
        send_frame(12'h001, '0, 12'hFFE);

        // largest limit, then lowered below the running count
        write_window_limit('1);
        repeat (6) send_frame('1, 12'hFFE, 12'h001);
        write_window_limit(12'd2);
        send_frame(12'h123, 12'h456, 12'h789);
        send_frame('0, '0, '0);

        for (int blk = 0; blk < 16; blk++) begin
            case (blk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (blk == 6) begin
                // long window with large sums, then a random limit that may close it
                write_window_limit('1);
                repeat (250) send_frame(SAMPLE_BITS'($urandom_range(4095, 3800)),
                                        pick_sample(), pick_sample());
            end
            pick = $urandom_range(9);
            if (pick < 5) begin
                limit = LIMIT_BITS'($urandom_range(8, 1));
            end else if (pick < 8) begin
                limit = LIMIT_BITS'($urandom_range(40));
            end else begin
                limit = LIMIT_BITS'($urandom_range(4095, 41));
            end
            write_window_limit(limit);
            repeat ($urandom_range(65, 25)) send_random_frame();
        end

        drain_results();
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
